### design/aso_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_pkg
// Shared types and constants for the screen orientation detector.
// ----------------------------------------------------------------------------
package aso_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TIME_BITS_DEF   = 64;
  localparam int TIME_IN_W       = 63;

  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;
  localparam int SETTLE_W   = 32;
  localparam int THR_W      = 15;
  localparam int THR_SQ_W   = 2 * THR_W;

  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 32'd250000000;
  localparam logic [THR_W-1:0]    THR_RESET    = 15'd1434;
  localparam logic [THR_SQ_W-1:0] THR_SQ_RESET = THR_SQ_W'(1434 * 1434);

  // tan(30 deg) in q16
  localparam logic [15:0] TAN30_Q16 = 16'd37837;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ENABLE         = 3'd0,
    REG_SWAP_XY        = 3'd1,
    REG_NEG_X          = 3'd2,
    REG_NEG_Y          = 3'd3,
    REG_ROT_OFFSET     = 3'd4,
    REG_SETTLE_TIME    = 3'd5,
    REG_FLAT_THRESHOLD = 3'd6
  } reg_idx_t;

  localparam logic [1:0] QUAD_POS_Y = 2'd0;
  localparam logic [1:0] QUAD_POS_X = 2'd1;
  localparam logic [1:0] QUAD_NEG_Y = 2'd2;
  localparam logic [1:0] QUAD_NEG_X = 2'd3;

  typedef struct packed {
    logic                enable;
    logic                swap_xy;
    logic                neg_x;
    logic                neg_y;
    logic [1:0]          rot_offset;
    logic [SETTLE_W-1:0] settle_time_ns;
    logic [THR_SQ_W-1:0] thr_sq;
    logic                track_clear;
  } cfg_t;

endpackage

### design/aso_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_cfg
// Configuration registers; keeps the flat threshold as its square.
// ----------------------------------------------------------------------------
module aso_cfg import aso_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  write_en,
  input  logic [REG_IDX_W-1:0]  reg_index,
  input  logic [CFG_DATA_W-1:0] write_data,
  output cfg_t                  cfg
);

  logic                enable;
  logic                swap_xy;
  logic                neg_x;
  logic                neg_y;
  logic [1:0]          rot_offset;
  logic [SETTLE_W-1:0] settle_time_ns;
  logic [THR_SQ_W-1:0] thr_sq;
  logic [THR_W-1:0]    thr_in;
  logic [THR_SQ_W-1:0] thr_sq_next;

  assign thr_in      = write_data[THR_W-1:0];
  assign thr_sq_next = THR_SQ_W'(thr_in) * THR_SQ_W'(thr_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      swap_xy        <= 1'b0;
      neg_x          <= 1'b0;
      neg_y          <= 1'b0;
      rot_offset     <= 2'd0;
      settle_time_ns <= SETTLE_RESET;
      thr_sq         <= THR_SQ_RESET;
    end else if (write_en) begin
      unique case (reg_index)
        REG_ENABLE:         enable         <= write_data[0];
        REG_SWAP_XY:        swap_xy        <= write_data[0];
        REG_NEG_X:          neg_x          <= write_data[0];
        REG_NEG_Y:          neg_y          <= write_data[0];
        REG_ROT_OFFSET:     rot_offset     <= write_data[1:0];
        REG_SETTLE_TIME:    settle_time_ns <= write_data[SETTLE_W-1:0];
        REG_FLAT_THRESHOLD: thr_sq         <= thr_sq_next;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.enable         = enable;
    cfg.swap_xy        = swap_xy;
    cfg.neg_x          = neg_x;
    cfg.neg_y          = neg_y;
    cfg.rot_offset     = rot_offset;
    cfg.settle_time_ns = settle_time_ns;
    cfg.thr_sq         = thr_sq;
    // any write of enable wipes the tracking state
    cfg.track_clear    = write_en && (reg_index == REG_ENABLE);
  end

endmodule

### design/aso_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_front
// Input register, axis mapping, quadrant pick and the two product terms.
// ----------------------------------------------------------------------------
module aso_front import aso_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cfg_t                                 cfg,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]        accel_x,
  input  logic signed [SAMPLE_BITS-1:0]        accel_y,
  input  logic [TIME_IN_W-1:0]                 time_ns,
  input  logic                                 s2_pop,
  output logic                                 s2_valid,
  output logic [2*SAMPLE_BITS:0]               s2_sum_sq,
  output logic [SAMPLE_BITS-1:0]               s2_minor,
  output logic [SAMPLE_BITS+15:0]              s2_major_prod,
  output logic [1:0]                           s2_quad,
  output logic [((TIME_BITS > TIME_IN_W) ? TIME_IN_W : TIME_BITS)-1:0] s2_now
);

  localparam int SW  = SAMPLE_BITS;
  localparam int TW  = (TIME_BITS > TIME_IN_W) ? TIME_IN_W : TIME_BITS;
  localparam int SQW = 2 * SW + 1;
  localparam int PW  = SW + 16;

  logic                 s1_valid;
  logic signed [SW-1:0] s1_x;
  logic signed [SW-1:0] s1_y;
  logic [TW-1:0]        s1_t;
  logic                 s1_ready;
  logic                 s2_ready;

  logic signed [SW:0] xe, ye, xi, yi, xs, ys, ax_full, ay_full;
  logic [SW-1:0]      ax, ay, major, minor;
  logic [1:0]         quad;
  logic [2*SW-1:0]    sq_x, sq_y;
  logic [SQW-1:0]     sum_sq;
  logic [PW-1:0]      major_prod;

  assign s2_ready     = !s2_valid || s2_pop;
  assign s1_ready     = !s1_valid || s2_ready;
  assign sample_stall = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= sample_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && sample_valid) begin
      s1_x <= accel_x;
      s1_y <= accel_y;
      s1_t <= time_ns[TW-1:0];
    end
    if (s2_ready && s1_valid) begin
      s2_sum_sq     <= sum_sq;
      s2_minor      <= minor;
      s2_major_prod <= major_prod;
      s2_quad       <= quad;
      s2_now        <= s1_t;
    end
  end

  always_comb begin
    // one extra bit so negating the most negative sample does not wrap
    xe = (SW+1)'(s1_x);
    ye = (SW+1)'(s1_y);
    xi = cfg.neg_x ? -xe : xe;
    yi = cfg.neg_y ? -ye : ye;
    xs = cfg.swap_xy ? yi : xi;
    ys = cfg.swap_xy ? xi : yi;

    ax_full = xs[SW] ? -xs : xs;
    ay_full = ys[SW] ? -ys : ys;
    ax      = ax_full[SW-1:0];
    ay      = ay_full[SW-1:0];

    if (ay >= ax) begin
      quad  = ys[SW] ? QUAD_NEG_Y : QUAD_POS_Y;
      major = ay;
      minor = ax;
    end else begin
      quad  = xs[SW] ? QUAD_NEG_X : QUAD_POS_X;
      major = ax;
      minor = ay;
    end

    sq_x       = (2*SW)'(ax) * (2*SW)'(ax);
    sq_y       = (2*SW)'(ay) * (2*SW)'(ay);
    sum_sq     = SQW'(sq_x) + SQW'(sq_y);
    major_prod = PW'(major) * PW'(TAN30_Q16);
  end

endmodule

### design/aso_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_track
// Sample screening, candidate and settle tracking, result register.
// ----------------------------------------------------------------------------
module aso_track import aso_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cfg_t                                 cfg,
  input  logic                                 s2_valid,
  input  logic [2*SAMPLE_BITS:0]               s2_sum_sq,
  input  logic [SAMPLE_BITS-1:0]               s2_minor,
  input  logic [SAMPLE_BITS+15:0]              s2_major_prod,
  input  logic [1:0]                           s2_quad,
  input  logic [((TIME_BITS > TIME_IN_W) ? TIME_IN_W : TIME_BITS)-1:0] s2_now,
  output logic                                 s2_pop,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [1:0]                           rotation
);

  localparam int SW  = SAMPLE_BITS;
  localparam int TW  = (TIME_BITS > TIME_IN_W) ? TIME_IN_W : TIME_BITS;
  localparam int SQW = 2 * SW + 1;
  localparam int CW  = (SQW > THR_SQ_W) ? SQW : THR_SQ_W;

  logic          rep_valid;
  logic [1:0]    rep_orient;
  logic          cand_valid;
  logic [1:0]    cand_orient;
  logic [TW-1:0] cand_start;

  logic          flat, steep, ok;
  logic [1:0]    rot;
  logic          cand_same;
  logic [TW-1:0] elapsed;
  logic          late, settled, report;
  logic          out_ready;
  logic          step;

  always_comb begin
    flat      = CW'(s2_sum_sq) < CW'(cfg.thr_sq);
    steep     = {s2_minor, 16'h0000} > s2_major_prod;
    ok        = !flat && !steep;
    rot       = s2_quad + cfg.rot_offset;
    cand_same = cand_valid && (rot == cand_orient);
    elapsed   = s2_now - cand_start;
    late      = (s2_now >= cand_start) && (elapsed >= TW'(cfg.settle_time_ns));
    // a fresh candidate starts now, so only a zero settle time lets it through
    settled   = cand_same ? late : (cfg.settle_time_ns == '0);
    report    = cfg.enable && ok && (!rep_valid || ((rot != rep_orient) && settled));
    out_ready = !result_valid || !result_stall;
    s2_pop    = s2_valid && (!report || out_ready);
    step      = s2_pop && cfg.enable;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.track_clear) begin
      rep_valid   <= 1'b0;
      rep_orient  <= 2'd0;
      cand_valid  <= 1'b0;
      cand_orient <= 2'd0;
      cand_start  <= '0;
    end else if (step) begin
      if (!ok) begin
        cand_valid <= 1'b0;
      end else if (!cand_same) begin
        cand_valid  <= 1'b1;
        cand_orient <= rot;
        cand_start  <= s2_now;
      end
      if (report) begin
        rep_valid  <= 1'b1;
        rep_orient <= rot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_pop && report) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_pop && report) begin
      rotation <= rot;
    end
  end

`ifndef SYNTHESIS
  a_report_latched: assert property (@(posedge clk) disable iff (rst)
    (s2_pop && report && !cfg.track_clear) |=> (rep_valid && rep_orient == $past(rot)))
    else $error("reported orientation not taken over after a report");

  a_reject_clears: assert property (@(posedge clk) disable iff (rst)
    (step && !ok) |=> !cand_valid)
    else $error("candidate survives a rejected sample");

  a_disabled_quiet: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !cfg.enable) |-> (!report && s2_pop))
    else $error("sample reported or held while disabled");

  a_result_from_report: assert property (@(posedge clk) disable iff (rst)
    (!$past(result_valid) && result_valid) |-> $past(s2_pop && report))
    else $error("result raised without a report");
`endif

endmodule

### design/accel_screen_orientation_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_screen_orientation_detector
// Portrait/landscape detection from accelerometer x/y samples.
//
//   channel   signals                          handshake
//   sample    accel_x, accel_y, time_ns        sample_valid / sample_stall
//   result    rotation                         result_valid / result_stall
//   config    reg_index, write_data            write_en (no wait)
//
// A sample is taken every cycle while sample_stall is low; it passes an
// input register, a product register and the tracking logic, and
// result_valid is registered behind the tracking logic. The multiplier
// behind the product register sets the cycle time. Reset is synchronous. A
// stalled result holds the tracking stage only when that stage has a result
// to hand over; samples that report nothing keep moving.
// ----------------------------------------------------------------------------
module accel_screen_orientation_detector import aso_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_en,
  input  logic [REG_IDX_W-1:0]          reg_index,
  input  logic [CFG_DATA_W-1:0]         write_data,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_y,
  input  logic [TIME_IN_W-1:0]          time_ns,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [1:0]                    rotation
);

  localparam int TW = (TIME_BITS > TIME_IN_W) ? TIME_IN_W : TIME_BITS;

  cfg_t                     cfg;
  logic                     s2_pop;
  logic                     s2_valid;
  logic [2*SAMPLE_BITS:0]   s2_sum_sq;
  logic [SAMPLE_BITS-1:0]   s2_minor;
  logic [SAMPLE_BITS+15:0]  s2_major_prod;
  logic [1:0]               s2_quad;
  logic [TW-1:0]            s2_now;

  aso_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .write_en   (write_en),
    .reg_index  (reg_index),
    .write_data (write_data),
    .cfg        (cfg)
  );

  aso_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .accel_x       (accel_x),
    .accel_y       (accel_y),
    .time_ns       (time_ns),
    .s2_pop        (s2_pop),
    .s2_valid      (s2_valid),
    .s2_sum_sq     (s2_sum_sq),
    .s2_minor      (s2_minor),
    .s2_major_prod (s2_major_prod),
    .s2_quad       (s2_quad),
    .s2_now        (s2_now)
  );

  aso_track #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_track (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s2_valid      (s2_valid),
    .s2_sum_sq     (s2_sum_sq),
    .s2_minor      (s2_minor),
    .s2_major_prod (s2_major_prod),
    .s2_quad       (s2_quad),
    .s2_now        (s2_now),
    .s2_pop        (s2_pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .rotation      (rotation)
  );

endmodule

### dv/aso_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_checker
// Follows register writes and both channels of the orientation detector,
// keeps its own copy of the tracking state, predicts each rotation report
// and compares the reports in order. Failures are counted for the top.
// ----------------------------------------------------------------------------
module aso_checker import aso_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  write_en,
  input  logic [REG_IDX_W-1:0]  reg_index,
  input  logic [CFG_DATA_W-1:0] write_data,
  input  logic                  sample_valid,
  input  logic                  sample_stall,
  input  logic signed [15:0]    accel_x,
  input  logic signed [15:0]    accel_y,
  input  logic [TIME_IN_W-1:0]  time_ns,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  logic [1:0]            rotation,
  output int                    errors,
  output int                    pending
);

  localparam int MAX_PRINTED = 100;

  logic                en_q;
  logic                swap_q;
  logic                inv_x_q;
  logic                inv_y_q;
  logic [1:0]          offset_q;
  logic [SETTLE_W-1:0] settle_q;
  logic [THR_W-1:0]    thr_q;

  logic        have_report;
  logic [1:0]  reported_rot;
  logic        have_cand;
  logic [1:0]  cand_rot;
  logic [63:0] cand_since;

  logic [1:0] expected_rot[$];
  logic [1:0] want;

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic clear_tracking();
    have_report  = 1'b0;
    reported_rot = '0;
    have_cand    = 1'b0;
    cand_rot     = '0;
    cand_since   = '0;
  endtask

  task automatic track_sample(input logic signed [15:0] sx, input logic signed [15:0] sy,
                              input logic [TIME_IN_W-1:0] stamp_in);
    longint      x, y, swap_tmp, ax, ay, major, minor;
    logic [1:0]  quad, rot;
    logic [63:0] stamp;
    if (!en_q) return;
    x = longint'(sx);
    y = longint'(sy);
    stamp = {1'b0, stamp_in};
    // negation at full width, so the most negative sample does not wrap
    if (inv_x_q) x = -x;
    if (inv_y_q) y = -y;
    if (swap_q) begin
      swap_tmp = x;
      x = y;
      y = swap_tmp;
    end
    if (x * x + y * y < longint'(thr_q) * longint'(thr_q)) begin
      have_cand = 1'b0;
      return;
    end
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    if (ay >= ax) begin
      quad  = (y >= 0) ? QUAD_POS_Y : QUAD_NEG_Y;
      major = ay;
      minor = ax;
    end else begin
      quad  = (x > 0) ? QUAD_POS_X : QUAD_NEG_X;
      major = ax;
      minor = ay;
    end
    // too close to a quadrant boundary
    if (minor * 65536 > major * longint'(TAN30_Q16)) begin
      have_cand = 1'b0;
      return;
    end
    rot = quad + offset_q;
    if (!have_cand || rot != cand_rot) begin
      have_cand  = 1'b1;
      cand_rot   = rot;
      cand_since = stamp;
    end
    if (have_report && rot == reported_rot) return;
    // later changes must hold for the settle time; time running back never settles
    if (have_report && (stamp < cand_since || stamp - cand_since < 64'(settle_q))) return;
    have_report  = 1'b1;
    reported_rot = rot;
    expected_rot = {expected_rot, rot};
  endtask

  always @(posedge clk) begin
    if (rst) begin
      en_q     = 1'b0;
      swap_q   = 1'b0;
      inv_x_q  = 1'b0;
      inv_y_q  = 1'b0;
      offset_q = '0;
      settle_q = SETTLE_RESET;
      thr_q    = THR_RESET;
      clear_tracking();
      expected_rot.delete();
    end else begin
      if (write_en) begin
        case (reg_index)
          REG_ENABLE: begin
            en_q = write_data[0];
            clear_tracking();
          end
          REG_SWAP_XY:        swap_q   = write_data[0];
          REG_NEG_X:          inv_x_q  = write_data[0];
          REG_NEG_Y:          inv_y_q  = write_data[0];
          REG_ROT_OFFSET:     offset_q = write_data[1:0];
          REG_SETTLE_TIME:    settle_q = write_data[SETTLE_W-1:0];
          REG_FLAT_THRESHOLD: thr_q    = write_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_rot.size() == 0) begin
          report_mismatch($sformatf("rotation %0d reported with nothing expected", rotation));
        end else begin
          want = expected_rot.pop_front();
          if (rotation !== want)
            report_mismatch($sformatf("rotation %0d, expected %0d", rotation, want));
        end
      end
      if (sample_valid && !sample_stall) track_sample(accel_x, accel_y, time_ns);
    end
    pending = expected_rot.size();
  end

endmodule

### dv/accel_screen_orientation_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_screen_orientation_detector_tb
// Drives the orientation detector with a short directed sequence and then
// phases of tilt runs under changing register settings, with random gaps
// on the sample side and random stalls on the result side. A checker
// beside the block predicts and compares every rotation report.
// ----------------------------------------------------------------------------
module accel_screen_orientation_detector_tb;
  import aso_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 86;
  localparam int QUIET_PHASES  = 2;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [TIME_IN_W-1:0] TIME_MAX   = '1;

  logic                  clk;
  logic                  rst;
  logic                  write_en;
  logic [REG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] write_data;
  logic                  sample_valid;
  logic                  sample_stall;
  logic signed [15:0]    accel_x;
  logic signed [15:0]    accel_y;
  logic [TIME_IN_W-1:0]  time_ns;
  logic                  result_valid;
  logic                  result_stall;
  logic [1:0]            rotation;

  int                   errors;
  int                   pending;
  int                   cycles;
  bit                   idle_on;
  int unsigned          cur_settle;
  int                   cur_thr;
  logic [TIME_IN_W-1:0] now_ns;

  accel_screen_orientation_detector u_dut (
    .clk          (clk),
    .rst          (rst),
    .write_en     (write_en),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .time_ns      (time_ns),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .rotation     (rotation)
  );

  aso_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .write_en     (write_en),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .time_ns      (time_ns),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .rotation     (rotation),
    .errors       (errors),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // result side back-pressure in bursts
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(11, 0) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(19, 1)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // keep the low bits, fill the unused upper bits with junk
  function automatic logic [CFG_DATA_W-1:0] with_noise(input logic [CFG_DATA_W-1:0] value,
                                                       input int bits);
    logic [CFG_DATA_W-1:0] mask;
    mask = (CFG_DATA_W'(1) << bits) - 1;
    return (CFG_DATA_W'($urandom) & ~mask) | (value & mask);
  endfunction

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    write_en   <= 1'b1;
    reg_index  <= idx;
    write_data <= value;
    @(negedge clk);
    write_en   <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic [TIME_IN_W-1:0] stamp);
    if (idle_on && $urandom_range(5, 0) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(negedge clk);
    end
    sample_valid <= 1'b1;
    accel_x      <= x;
    accel_y      <= y;
    time_ns      <= stamp;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // wait until every report is in and the pipeline has emptied
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // well-formed tilt: strong enough and within 30 degrees of the axis
  task automatic make_tilt(input logic [1:0] dir, output logic signed [15:0] x,
                           output logic signed [15:0] y);
    int major, minor;
    major = $urandom_range(32767, cur_thr);
    if ((dir == QUAD_NEG_X || dir == QUAD_NEG_Y) && $urandom_range(15, 0) == 0) major = 32768;
    minor = $urandom_range((major * int'(TAN30_Q16)) >>> 16, 0);
    if ($urandom_range(1, 0)) minor = -minor;
    case (dir)
      QUAD_POS_Y: begin
        x = 16'(minor);
        y = 16'(major);
      end
      QUAD_POS_X: begin
        x = 16'(major);
        y = 16'(minor);
      end
      QUAD_NEG_Y: begin
        x = 16'(minor);
        y = 16'(-major);
      end
      default: begin
        x = 16'(-major);
        y = 16'(minor);
      end
    endcase
  endtask

  task automatic make_noise(output logic signed [15:0] x, output logic signed [15:0] y);
    int major, minor;
    case ($urandom_range(3, 0))
      0: begin
        // lying flat
        x = 16'($urandom_range(cur_thr / 2, 0));
        y = 16'($urandom_range(cur_thr / 2, 0));
      end
      1: begin
        // on the tan30 edge or one step past it
        major = $urandom_range(32767, 1);
        minor = ((major * int'(TAN30_Q16)) >>> 16) + $urandom_range(1, 0);
        if ($urandom_range(1, 0)) begin
          x = 16'(major);
          y = 16'(minor);
        end else begin
          x = 16'(minor);
          y = 16'(major);
        end
      end
      2: begin
        x = 16'($urandom);
        y = x;
      end
      default: begin
        x = 16'($urandom);
        y = 16'($urandom);
      end
    endcase
    if ($urandom_range(1, 0)) x = -x;
    if ($urandom_range(1, 0)) y = -y;
  endtask

  initial begin
    logic signed [15:0]   x, y;
    logic [TIME_IN_W-1:0] stamp;
    logic [1:0]           dir;
    int                   p, sent, run_len;
    int unsigned          step_max;

    rst          <= 1'b1;
    write_en     <= 1'b0;
    reg_index    <= '0;
    write_data   <= '0;
    sample_valid <= 1'b0;
    accel_x      <= '0;
    accel_y      <= '0;
    time_ns      <= '0;
    idle_on      = 1'b1;
    cur_settle   = SETTLE_RESET;
    cur_thr      = int'(THR_RESET);
    now_ns       = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset settings: first report at once, later ones after the settle time
    write_reg(REG_UNUSED, $urandom);
    write_reg(REG_ENABLE, 1);
    send_sample(0, 4096, 1000);
    send_sample(4096, 0, 2000);
    send_sample(4096, 100, 250002000);
    send_sample(100, -100, 250002001);
    send_sample(-32768, 0, 250002002);
    send_sample(32767, 32767, 250002003);
    send_sample(0, -32768, 300000000);
    send_sample(0, -32768, 299999999);
    send_sample(11546, -20000, 300000001);
    send_sample(0, -32768, TIME_MAX);
    send_sample(11547, -20000, TIME_MAX);
    send_sample(-4096, 0, 0);
    send_sample(32767, -32768, 5);

    // disabled block ignores samples
    drain_results();
    write_reg(REG_ENABLE, 0);
    send_sample(4096, 0, 20);
    send_sample(-32768, 32767, 21);

    // all axis options on, no flat threshold, no settle time
    drain_results();
    write_reg(REG_FLAT_THRESHOLD, 0);
    write_reg(REG_SWAP_XY, 1);
    write_reg(REG_NEG_X, 1);
    write_reg(REG_NEG_Y, 1);
    write_reg(REG_ROT_OFFSET, 3);
    write_reg(REG_SETTLE_TIME, 0);
    write_reg(REG_ENABLE, 1);
    send_sample(0, 0, 10);
    send_sample(-32768, 0, 10);
    send_sample(0, -32768, 11);
    send_sample(-32768, -32768, 12);
    send_sample(32767, -5, 12);
    send_sample(1, 0, 13);

    for (p = 0; p < PHASES; p++) begin
      drain_results();
      idle_on = (p < PHASES - QUIET_PHASES);
      case (p % 5)
        0:       cur_settle = 0;
        1:       cur_settle = $urandom_range(64, 1);
        2:       cur_settle = $urandom_range(5000, 100);
        3:       cur_settle = 32'hFFFF_FFFF;
        default: cur_settle = SETTLE_RESET;
      endcase
      case (p % 4)
        0:       cur_thr = int'(THR_RESET);
        1:       cur_thr = 0;
        2:       cur_thr = $urandom_range(4096, 1);
        default: cur_thr = (p == 3) ? 32767 : $urandom_range(32767, 0);
      endcase
      write_reg(REG_SWAP_XY, with_noise($urandom_range(1, 0), 1));
      write_reg(REG_NEG_X, with_noise($urandom_range(1, 0), 1));
      write_reg(REG_NEG_Y, with_noise($urandom_range(1, 0), 1));
      write_reg(REG_ROT_OFFSET, with_noise(p % 4, 2));
      write_reg(REG_SETTLE_TIME, cur_settle);
      write_reg(REG_FLAT_THRESHOLD, with_noise(cur_thr, THR_W));
      if ($urandom_range(3, 0) == 0) write_reg(REG_UNUSED, $urandom);
      write_reg(REG_ENABLE, with_noise(1, 1));
      now_ns = TIME_IN_W'({8'($urandom), 32'($urandom)});

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // hold one direction for a run, with a pace that may or may not settle
        dir     = 2'($urandom_range(3, 0));
        run_len = $urandom_range(12, 1);
        case ($urandom_range(2, 0))
          0:       step_max = 0;
          1:       step_max = cur_settle / 4;
          default: step_max = cur_settle / 2 + 1;
        endcase
        if (p < PHASES - QUIET_PHASES) idle_on = ($urandom_range(2, 0) != 0);
        repeat (run_len) begin
          now_ns += TIME_IN_W'($urandom_range(step_max, 0));
          stamp = now_ns;
          if ($urandom_range(99, 0) < 85) begin
            make_tilt(dir, x, y);
          end else begin
            make_noise(x, y);
            if ($urandom_range(4, 0) == 0 && now_ns > 1000)
              stamp = now_ns - TIME_IN_W'($urandom_range(1000, 1));
          end
          send_sample(x, y, stamp);
          sent++;
        end
      end
    end

    drain_results();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
